[rtl/caf_pkg.sv]
// Shared types, constants and the arctangent table of the attitude filter.
package caf_pkg;

   localparam int CORDIC_W     = 36;
   localparam int CORDIC_STEPS = 30;
   localparam int CSR_INDEX_W  = 8;

   typedef logic signed [CORDIC_W-1:0] cvec_type;

   localparam cvec_type PI_Q30      = 36'sd3373259426;
   localparam cvec_type HALF_PI_Q30 = 36'sd1686629713;
   localparam logic [29:0] K_Q30    = 30'd652032874;

   localparam logic [CSR_INDEX_W-1:0] CSR_BLEND_WEIGHT = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIME_STEP    = 8'd1;

   localparam logic [15:0] BLEND_WEIGHT_RESET = 16'd58982;
   localparam logic [15:0] TIME_STEP_RESET    = 16'd328;

   typedef enum logic {
      CORDIC_VECTOR,
      CORDIC_ROTATE
   } cordic_mode_type;

   typedef struct packed {
      logic            start;
      cordic_mode_type mode;
   } cordic_ctrl_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_NORM_ACC,
      ST_VEC_ROLL,
      ST_MULK_LEN,
      ST_VEC_PITCH,
      ST_NORM_MAG,
      ST_ROT_PITCH,
      ST_MULK_A,
      ST_MULK_B,
      ST_ROT_ROLL,
      ST_MULK_C,
      ST_VEC_HEAD,
      ST_STORE,
      ST_GYRO,
      ST_DONE
   } caf_state_type;

   typedef enum logic [2:0] {
      BL_IDLE,
      BL_RATE,
      BL_DIV,
      BL_SUM,
      BL_MUL_NEW,
      BL_MUL_REF,
      BL_FINISH
   } blend_phase_type;

   function automatic logic [30:0] atan_entry(input logic [4:0] idx);
      logic [30:0] val;
      unique case (idx)
         5'd0:  val = 31'd843314856;
         5'd1:  val = 31'd497837829;
         5'd2:  val = 31'd263043836;
         5'd3:  val = 31'd133525158;
         5'd4:  val = 31'd67021686;
         5'd5:  val = 31'd33543515;
         5'd6:  val = 31'd16775850;
         5'd7:  val = 31'd8388437;
         5'd8:  val = 31'd4194282;
         5'd9:  val = 31'd2097149;
         5'd10: val = 31'd1048575;
         5'd11: val = 31'd524287;
         5'd12: val = 31'd262143;
         5'd13: val = 31'd131071;
         5'd14: val = 31'd65535;
         5'd15: val = 31'd32767;
         5'd16: val = 31'd16383;
         5'd17: val = 31'd8191;
         5'd18: val = 31'd4095;
         5'd19: val = 31'd2047;
         5'd20: val = 31'd1023;
         5'd21: val = 31'd511;
         5'd22: val = 31'd255;
         5'd23: val = 31'd127;
         5'd24: val = 31'd63;
         5'd25: val = 31'd31;
         5'd26: val = 31'd15;
         5'd27: val = 31'd8;
         5'd28: val = 31'd4;
         5'd29: val = 31'd2;
         default: val = 31'd0;
      endcase
      return val;
   endfunction

endpackage

[rtl/caf_cordic.sv]
// Iterative CORDIC unit, vectoring and rotation, one micro-rotation per cycle.
module caf_cordic (
   input  logic                     clock,
   input  logic                     reset,
   input  caf_pkg::cordic_ctrl_type ctrl,
   input  caf_pkg::cvec_type        x_load,
   input  caf_pkg::cvec_type        y_load,
   input  caf_pkg::cvec_type        z_load,
   output logic                     done,
   output caf_pkg::cvec_type        x_res,
   output caf_pkg::cvec_type        y_res,
   output caf_pkg::cvec_type        z_res
);

   caf_pkg::cvec_type x_ff, x_in, y_ff, y_in, z_ff, z_in;
   caf_pkg::cvec_type dx, dy, at;
   caf_pkg::cordic_mode_type mode_ff, mode_in;
   logic [4:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, zero_ff, zero_in, done_ff, done_in;

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      mode_in = mode_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      zero_in = zero_ff;
      done_in = 1'b0;
      dx      = x_ff >>> cnt_ff;
      dy      = y_ff >>> cnt_ff;
      at      = {5'd0, caf_pkg::atan_entry(cnt_ff)};
      if (ctrl.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         zero_in = 1'b0;
         mode_in = ctrl.mode;
         x_in    = x_load;
         y_in    = y_load;
         z_in    = z_load;
         if (ctrl.mode == caf_pkg::CORDIC_VECTOR) begin
            z_in = '0;
            if (x_load == '0 && y_load == '0) begin
               zero_in = 1'b1;
            end else if (x_load < 0) begin
               x_in = -x_load;
               y_in = -y_load;
               z_in = (y_load >= 0) ? caf_pkg::PI_Q30 : -caf_pkg::PI_Q30;
            end
         end else begin
            if (z_load > caf_pkg::HALF_PI_Q30) begin
               z_in = z_load - caf_pkg::PI_Q30;
               x_in = -x_load;
               y_in = -y_load;
            end else if (z_load < -caf_pkg::HALF_PI_Q30) begin
               z_in = z_load + caf_pkg::PI_Q30;
               x_in = -x_load;
               y_in = -y_load;
            end
         end
      end else if (busy_ff) begin
         if (!zero_ff) begin
            if (mode_ff == caf_pkg::CORDIC_VECTOR) begin
               if (y_ff > 0) begin
                  x_in = x_ff + dy;
                  y_in = y_ff - dx;
                  z_in = z_ff + at;
               end else begin
                  x_in = x_ff - dy;
                  y_in = y_ff + dx;
                  z_in = z_ff - at;
               end
            end else begin
               if (z_ff >= 0) begin
                  x_in = x_ff - dy;
                  y_in = y_ff + dx;
                  z_in = z_ff - at;
               end else begin
                  x_in = x_ff + dy;
                  y_in = y_ff - dx;
                  z_in = z_ff + at;
               end
            end
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(caf_pkg::CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         zero_ff <= 1'b0;
         cnt_ff  <= '0;
         mode_ff <= caf_pkg::CORDIC_VECTOR;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         zero_ff <= zero_in;
         cnt_ff  <= cnt_in;
         mode_ff <= mode_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign done  = done_ff;
   assign x_res = x_ff;
   assign y_res = y_ff;
   assign z_res = z_ff;

endmodule

[rtl/caf_mulk.sv]
// Shift-add multiplier that removes the CORDIC gain, rounded to nearest.
module caf_mulk (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  caf_pkg::cvec_type v_load,
   output logic              done,
   output caf_pkg::cvec_type result
);

   localparam int ACC_W = caf_pkg::CORDIC_W + 2;
   localparam logic signed [ACC_W-1:0] ROUND_HALF = {{(ACC_W-30){1'b0}}, 1'b1, 29'd0};

   logic signed [ACC_W-1:0] acc_ff, acc_in, addend, sum;
   caf_pkg::cvec_type v_ff, v_in;
   logic [4:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      acc_in  = acc_ff;
      v_in    = v_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      addend  = caf_pkg::K_Q30[cnt_ff] ? {{2{v_ff[caf_pkg::CORDIC_W-1]}}, v_ff} : '0;
      sum     = acc_ff + addend;
      if (start) begin
         acc_in  = ROUND_HALF;
         v_in    = v_load;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = sum >>> 1;
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd29) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff <= acc_in;
      v_ff   <= v_in;
   end

   assign done   = done_ff;
   assign result = acc_ff[caf_pkg::CORDIC_W-1:0];

endmodule

[rtl/caf_blend.sv]
// Gyro blend of one axis: rate integration, constant division and weighted mix.
module caf_blend #(
   parameter int SAMPLE_WIDTH = 16,
   parameter int ANGLE_WIDTH  = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic signed [ANGLE_WIDTH-1:0]  angle,
   input  logic signed [ANGLE_WIDTH-1:0]  ref_angle,
   input  logic signed [SAMPLE_WIDTH-1:0] rate,
   input  logic [15:0]                    alpha,
   input  logic [15:0]                    dt,
   output logic                           done,
   output logic signed [ANGLE_WIDTH-1:0]  result
);

   localparam int AF   = ANGLE_WIDTH - 3;
   localparam int UP   = (AF > 20) ? AF - 20 : 0;
   localparam int DOWN = (AF < 20) ? 20 - AF : 0;
   localparam int DV   = 286 * (2 ** DOWN);
   localparam int NW   = SAMPLE_WIDTH + 19 + UP;
   localparam int DS   = DOWN + 1;
   localparam int YW   = NW - DS;
   localparam int KS   = YW + 8;
   localparam int MW   = KS - 7;
   localparam int MAW  = (SAMPLE_WIDTH > ANGLE_WIDTH + 2) ? SAMPLE_WIDTH : ANGLE_WIDTH + 2;
   localparam int PW   = MAW + 18;
   localparam int XW   = ((PW > NW) ? PW : NW) + 1;
   localparam int SW2  = ANGLE_WIDTH + 2;
   localparam int ACW  = PW + 1;

   // ceil(2^KS / 143): exact floor quotient for every YW-bit dividend
   function automatic logic [MW-1:0] recip_143();
      logic [MW-1:0] q;
      int rem;
      q   = '0;
      rem = 1;
      for (int i = 0; i < KS; i++) begin
         rem = rem * 2;
         q   = {q[MW-2:0], (rem >= 143)};
         if (rem >= 143) begin
            rem = rem - 143;
         end
      end
      if (rem != 0) begin
         q = q + MW'(1);
      end
      return q;
   endfunction

   localparam logic [MW-1:0] RECIP = recip_143();

   caf_pkg::blend_phase_type phase_ff, phase_in;
   logic [NW-1:0] num_ff, num_in;
   logic [YW+MW-1:0] quot_prod;
   logic neg_ff, neg_in, done_ff, done_in;
   logic signed [SW2-1:0] sum_ff, sum_in;
   logic signed [ACW-1:0] acc_ff, acc_in, rnd, shr;
   logic signed [ANGLE_WIDTH-1:0] result_ff, result_in;
   logic signed [MAW-1:0] mul_a;
   logic [16:0] mul_b;
   logic signed [PW-1:0] prod;
   logic signed [XW-1:0] n_wide, n_scaled, n_mag;
   logic signed [NW+1:0] sum_w;

   assign prod      = mul_a * $signed({1'b0, mul_b});
   assign quot_prod = num_ff[NW-1:DS] * RECIP;

   always_comb begin
      phase_in  = phase_ff;
      num_in    = num_ff;
      neg_in    = neg_ff;
      sum_in    = sum_ff;
      acc_in    = acc_ff;
      result_in = result_ff;
      done_in   = 1'b0;
      mul_a     = {{(MAW-SAMPLE_WIDTH){rate[SAMPLE_WIDTH-1]}}, rate};
      mul_b     = {1'b0, dt};
      n_wide    = {{(XW-PW){prod[PW-1]}}, prod};
      n_scaled  = ((n_wide <<< 2) + n_wide) <<< UP;
      n_mag     = n_scaled[XW-1] ? -n_scaled : n_scaled;
      sum_w     = (neg_ff ? -$signed({2'b00, num_ff}) : $signed({2'b00, num_ff}))
                  + {{(NW+2-ANGLE_WIDTH){angle[ANGLE_WIDTH-1]}}, angle};
      rnd       = acc_ff + ACW'(32768);
      shr       = rnd >>> 16;
      unique case (phase_ff)
         caf_pkg::BL_IDLE: begin
            if (start) begin
               phase_in = caf_pkg::BL_RATE;
            end
         end
         caf_pkg::BL_RATE: begin
            num_in   = n_mag[NW-1:0] + NW'(DV / 2);
            neg_in   = n_scaled[XW-1];
            phase_in = caf_pkg::BL_DIV;
         end
         caf_pkg::BL_DIV: begin
            num_in   = {{(DS+7){1'b0}}, quot_prod[YW+MW-1:KS]};
            phase_in = caf_pkg::BL_SUM;
         end
         caf_pkg::BL_SUM: begin
            if (&sum_w[NW+1:SW2-1] || ~|sum_w[NW+1:SW2-1]) begin
               sum_in = sum_w[SW2-1:0];
            end else begin
               sum_in = sum_w[NW+1] ? {1'b1, {(SW2-1){1'b0}}} : {1'b0, {(SW2-1){1'b1}}};
            end
            phase_in = caf_pkg::BL_MUL_NEW;
         end
         caf_pkg::BL_MUL_NEW: begin
            mul_a    = {{(MAW-SW2){sum_ff[SW2-1]}}, sum_ff};
            mul_b    = {1'b0, alpha};
            acc_in   = {prod[PW-1], prod};
            phase_in = caf_pkg::BL_MUL_REF;
         end
         caf_pkg::BL_MUL_REF: begin
            mul_a    = {{(MAW-ANGLE_WIDTH){ref_angle[ANGLE_WIDTH-1]}}, ref_angle};
            mul_b    = 17'd65536 - {1'b0, alpha};
            acc_in   = acc_ff + {prod[PW-1], prod};
            phase_in = caf_pkg::BL_FINISH;
         end
         caf_pkg::BL_FINISH: begin
            if (&shr[ACW-1:ANGLE_WIDTH-1] || ~|shr[ACW-1:ANGLE_WIDTH-1]) begin
               result_in = shr[ANGLE_WIDTH-1:0];
            end else begin
               result_in = shr[ACW-1] ? {1'b1, {(ANGLE_WIDTH-1){1'b0}}}
                                      : {1'b0, {(ANGLE_WIDTH-1){1'b1}}};
            end
            done_in  = 1'b1;
            phase_in = caf_pkg::BL_IDLE;
         end
         default: phase_in = caf_pkg::BL_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= caf_pkg::BL_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      num_ff    <= num_in;
      neg_ff    <= neg_in;
      sum_ff    <= sum_in;
      acc_ff    <= acc_in;
      result_ff <= result_in;
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

[rtl/complementary_attitude_filter.sv]
// Top level of the complementary attitude filter: sequencer, state and ports.
//
// Input channel req_*: one transaction per sensor item. req_func = 1 carries
// accel/mag samples and refreshes the tilt roll, tilt pitch and magnetic
// heading references; req_func = 0 carries gyro rates and blends the fused
// roll, pitch and yaw towards those references. Either kind returns one
// rsp_* transaction with the fused angles after the item.
// Configuration channel csr_*: csr_index 0 writes blend_weight, 1 writes
// time_step, other indexes are ignored; always ready. Write only when idle.
// Throughput: one item at a time; req_ready is high only while idle.
// A gyro item runs the three axis blends in turn, then loads the result
// register and raises rsp_valid as the filter returns to idle.
// An accel/mag item runs five CORDIC passes, four gain multiplies and
// two shift normalisations set in length by the largest sample magnitude.
// Reset zeroes the tilt and fused angles and loads the register defaults.
// A stalled rsp_ready holds the result; the next item may be accepted
// meanwhile and waits at its end until the result register is free.
module complementary_attitude_filter #(
   parameter int SAMPLE_WIDTH = 16,
   parameter int ANGLE_WIDTH  = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_func,
   input  logic signed [SAMPLE_WIDTH-1:0]      req_accel_x,
   input  logic signed [SAMPLE_WIDTH-1:0]      req_accel_y,
   input  logic signed [SAMPLE_WIDTH-1:0]      req_accel_z,
   input  logic signed [SAMPLE_WIDTH-1:0]      req_mag_x,
   input  logic signed [SAMPLE_WIDTH-1:0]      req_mag_y,
   input  logic signed [SAMPLE_WIDTH-1:0]      req_mag_z,
   input  logic signed [SAMPLE_WIDTH-1:0]      req_rate_x,
   input  logic signed [SAMPLE_WIDTH-1:0]      req_rate_y,
   input  logic signed [SAMPLE_WIDTH-1:0]      req_rate_z,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [ANGLE_WIDTH-1:0]       rsp_roll_angle,
   output logic signed [ANGLE_WIDTH-1:0]       rsp_pitch_angle,
   output logic signed [ANGLE_WIDTH-1:0]       rsp_yaw_angle,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [caf_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [15:0]                         csr_data
);

   localparam int DW = caf_pkg::CORDIC_W;
   localparam int RK = 33 - ANGLE_WIDTH;
   localparam logic [1:0] LAST_AXIS = 2'd2;

   caf_pkg::caf_state_type state_ff, state_in;
   logic launch_ff, launch_in;
   caf_pkg::cvec_type v_ff [3];
   caf_pkg::cvec_type v_in [3];
   logic signed [SAMPLE_WIDTH-1:0] s_ff [3];
   logic signed [SAMPLE_WIDTH-1:0] s_in [3];
   caf_pkg::cvec_type r30_ff, r30_in, p30_ff, p30_in, t0_ff, t0_in, t1_ff, t1_in;
   logic signed [ANGLE_WIDTH-1:0] tilt_ff [3];
   logic signed [ANGLE_WIDTH-1:0] tilt_in [3];
   logic signed [ANGLE_WIDTH-1:0] fused_ff [3];
   logic signed [ANGLE_WIDTH-1:0] fused_in [3];
   logic [1:0] axis_ff, axis_in;
   logic [15:0] alpha_ff, alpha_in, dt_ff, dt_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [ANGLE_WIDTH-1:0] rsp_roll_ff, rsp_roll_in, rsp_pitch_ff, rsp_pitch_in;
   logic signed [ANGLE_WIDTH-1:0] rsp_yaw_ff, rsp_yaw_in;

   caf_pkg::cordic_ctrl_type cctl;
   caf_pkg::cvec_type cx_load, cy_load, cz_load, cx, cy, cz;
   logic c_done;
   logic mk_start, mk_done;
   caf_pkg::cvec_type mk_v, mk_res;
   logic bl_start, bl_done;
   logic signed [ANGLE_WIDTH-1:0] bl_res;

   logic [DW-1:0] m0, m1, m2, m_max;
   logic norm_done;

   function automatic logic [DW-1:0] absval(input caf_pkg::cvec_type v);
      return v[DW-1] ? -v : v;
   endfunction

   function automatic logic signed [ANGLE_WIDTH-1:0] to_angle(input caf_pkg::cvec_type v);
      logic signed [DW:0] rs;
      logic signed [DW:0] sh;
      logic signed [ANGLE_WIDTH-1:0] res;
      rs = {v[DW-1], v} + (DW+1)'(2 ** (RK - 1));
      sh = rs >>> RK;
      if (&sh[DW:ANGLE_WIDTH-1] || ~|sh[DW:ANGLE_WIDTH-1]) begin
         res = sh[ANGLE_WIDTH-1:0];
      end else begin
         res = sh[DW] ? {1'b1, {(ANGLE_WIDTH-1){1'b0}}} : {1'b0, {(ANGLE_WIDTH-1){1'b1}}};
      end
      return res;
   endfunction

   caf_cordic u_cordic (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (cctl),
      .x_load (cx_load),
      .y_load (cy_load),
      .z_load (cz_load),
      .done   (c_done),
      .x_res  (cx),
      .y_res  (cy),
      .z_res  (cz)
   );

   caf_mulk u_mulk (
      .clock  (clock),
      .reset  (reset),
      .start  (mk_start),
      .v_load (mk_v),
      .done   (mk_done),
      .result (mk_res)
   );

   caf_blend #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .ANGLE_WIDTH  (ANGLE_WIDTH)
   ) u_blend (
      .clock     (clock),
      .reset     (reset),
      .start     (bl_start),
      .angle     (fused_ff[axis_ff]),
      .ref_angle (tilt_ff[axis_ff]),
      .rate      (s_ff[axis_ff]),
      .alpha     (alpha_ff),
      .dt        (dt_ff),
      .done      (bl_done),
      .result    (bl_res)
   );

   assign req_ready = (state_ff == caf_pkg::ST_IDLE);
   assign csr_ready = 1'b1;

   always_comb begin
      m0        = absval(v_ff[0]);
      m1        = absval(v_ff[1]);
      m2        = absval(v_ff[2]);
      m_max     = m0;
      if (m1 > m_max) m_max = m1;
      if (m2 > m_max) m_max = m2;
      norm_done = (m_max == '0) || (~|m_max[DW-1:30] && m_max[29]);
   end

   always_comb begin
      state_in     = state_ff;
      launch_in    = 1'b0;
      v_in         = v_ff;
      s_in         = s_ff;
      r30_in       = r30_ff;
      p30_in       = p30_ff;
      t0_in        = t0_ff;
      t1_in        = t1_ff;
      tilt_in      = tilt_ff;
      fused_in     = fused_ff;
      axis_in      = axis_ff;
      alpha_in     = alpha_ff;
      dt_in        = dt_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_roll_in  = rsp_roll_ff;
      rsp_pitch_in = rsp_pitch_ff;
      rsp_yaw_in   = rsp_yaw_ff;
      cctl.start   = 1'b0;
      cctl.mode    = caf_pkg::CORDIC_VECTOR;
      cx_load      = '0;
      cy_load      = '0;
      cz_load      = '0;
      mk_start     = 1'b0;
      mk_v         = cx;
      bl_start     = 1'b0;

      if (csr_valid) begin
         unique case (csr_index)
            caf_pkg::CSR_BLEND_WEIGHT: alpha_in = csr_data;
            caf_pkg::CSR_TIME_STEP:    dt_in    = csr_data;
            default: ;
         endcase
      end

      unique case (state_ff) inside
         caf_pkg::ST_IDLE: begin
            if (req_valid) begin
               v_in[0] = {{(DW-SAMPLE_WIDTH){req_accel_x[SAMPLE_WIDTH-1]}}, req_accel_x};
               v_in[1] = {{(DW-SAMPLE_WIDTH){req_accel_y[SAMPLE_WIDTH-1]}}, req_accel_y};
               v_in[2] = {{(DW-SAMPLE_WIDTH){req_accel_z[SAMPLE_WIDTH-1]}}, req_accel_z};
               if (req_func) begin
                  s_in[0]  = req_mag_x;
                  s_in[1]  = req_mag_y;
                  s_in[2]  = req_mag_z;
                  state_in = caf_pkg::ST_NORM_ACC;
               end else begin
                  s_in[0]   = req_rate_x;
                  s_in[1]   = req_rate_y;
                  s_in[2]   = req_rate_z;
                  axis_in   = '0;
                  launch_in = 1'b1;
                  state_in  = caf_pkg::ST_GYRO;
               end
            end
         end
         caf_pkg::ST_NORM_ACC, caf_pkg::ST_NORM_MAG: begin
            if (norm_done) begin
               launch_in = 1'b1;
               state_in  = (state_ff == caf_pkg::ST_NORM_ACC) ? caf_pkg::ST_VEC_ROLL
                                                              : caf_pkg::ST_ROT_PITCH;
            end else if (|m_max[DW-1:30]) begin
               for (int i = 0; i < 3; i++) v_in[i] = v_ff[i] >>> 1;
            end else begin
               for (int i = 0; i < 3; i++) v_in[i] = v_ff[i] <<< 1;
            end
         end
         caf_pkg::ST_VEC_ROLL: begin
            cctl.start = launch_ff;
            cx_load    = v_ff[2];
            cy_load    = v_ff[1];
            if (c_done) begin
               r30_in    = cz;
               launch_in = 1'b1;
               state_in  = caf_pkg::ST_MULK_LEN;
            end
         end
         caf_pkg::ST_MULK_LEN: begin
            mk_start = launch_ff;
            mk_v     = cx;
            if (mk_done) begin
               launch_in = 1'b1;
               state_in  = caf_pkg::ST_VEC_PITCH;
            end
         end
         caf_pkg::ST_VEC_PITCH: begin
            cctl.start = launch_ff;
            cx_load    = mk_res;
            cy_load    = -v_ff[0];
            if (c_done) begin
               p30_in = cz;
               for (int i = 0; i < 3; i++) begin
                  v_in[i] = {{(DW-SAMPLE_WIDTH){s_ff[i][SAMPLE_WIDTH-1]}}, s_ff[i]};
               end
               state_in = caf_pkg::ST_NORM_MAG;
            end
         end
         caf_pkg::ST_ROT_PITCH: begin
            cctl.start = launch_ff;
            cctl.mode  = caf_pkg::CORDIC_ROTATE;
            cx_load    = v_ff[0];
            cy_load    = v_ff[2];
            cz_load    = -p30_ff;
            if (c_done) begin
               launch_in = 1'b1;
               state_in  = caf_pkg::ST_MULK_A;
            end
         end
         caf_pkg::ST_MULK_A: begin
            mk_start = launch_ff;
            mk_v     = cx;
            if (mk_done) begin
               t0_in     = mk_res;
               launch_in = 1'b1;
               state_in  = caf_pkg::ST_MULK_B;
            end
         end
         caf_pkg::ST_MULK_B: begin
            mk_start = launch_ff;
            mk_v     = cy;
            if (mk_done) begin
               t1_in     = mk_res;
               launch_in = 1'b1;
               state_in  = caf_pkg::ST_ROT_ROLL;
            end
         end
         caf_pkg::ST_ROT_ROLL: begin
            cctl.start = launch_ff;
            cctl.mode  = caf_pkg::CORDIC_ROTATE;
            cx_load    = v_ff[1];
            cy_load    = t1_ff;
            cz_load    = r30_ff;
            if (c_done) begin
               launch_in = 1'b1;
               state_in  = caf_pkg::ST_MULK_C;
            end
         end
         caf_pkg::ST_MULK_C: begin
            mk_start = launch_ff;
            mk_v     = cx;
            if (mk_done) begin
               t1_in     = mk_res;
               launch_in = 1'b1;
               state_in  = caf_pkg::ST_VEC_HEAD;
            end
         end
         caf_pkg::ST_VEC_HEAD: begin
            cctl.start = launch_ff;
            cx_load    = t0_ff;
            cy_load    = -t1_ff;
            if (c_done) begin
               state_in = caf_pkg::ST_STORE;
            end
         end
         caf_pkg::ST_STORE: begin
            tilt_in[0] = to_angle(r30_ff);
            tilt_in[1] = to_angle(p30_ff);
            tilt_in[2] = to_angle(cz);
            state_in   = caf_pkg::ST_DONE;
         end
         caf_pkg::ST_GYRO: begin
            bl_start = launch_ff;
            if (bl_done) begin
               fused_in[axis_ff] = bl_res;
               if (axis_ff == LAST_AXIS) begin
                  state_in = caf_pkg::ST_DONE;
               end else begin
                  axis_in   = axis_ff + 2'd1;
                  launch_in = 1'b1;
               end
            end
         end
         caf_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_roll_in  = fused_ff[0];
               rsp_pitch_in = fused_ff[1];
               rsp_yaw_in   = fused_ff[2];
               state_in     = caf_pkg::ST_IDLE;
            end
         end
         default: state_in = caf_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= caf_pkg::ST_IDLE;
         launch_ff    <= 1'b0;
         axis_ff      <= '0;
         alpha_ff     <= caf_pkg::BLEND_WEIGHT_RESET;
         dt_ff        <= caf_pkg::TIME_STEP_RESET;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            tilt_ff[i]  <= '0;
            fused_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         launch_ff    <= launch_in;
         axis_ff      <= axis_in;
         alpha_ff     <= alpha_in;
         dt_ff        <= dt_in;
         rsp_valid_ff <= rsp_valid_in;
         tilt_ff      <= tilt_in;
         fused_ff     <= fused_in;
      end
      v_ff         <= v_in;
      s_ff         <= s_in;
      r30_ff       <= r30_in;
      p30_ff       <= p30_in;
      t0_ff        <= t0_in;
      t1_ff        <= t1_in;
      rsp_roll_ff  <= rsp_roll_in;
      rsp_pitch_ff <= rsp_pitch_in;
      rsp_yaw_ff   <= rsp_yaw_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_roll_angle  = rsp_roll_ff;
   assign rsp_pitch_angle = rsp_pitch_ff;
   assign rsp_yaw_angle   = rsp_yaw_ff;

endmodule
